// File: design/battery_breathing_led_driver_unit_assert.svh
// ----------------------------------------------------------------------------
// battery breathing led driver assertion macros
// shared property forms used by the driver modules
// ----------------------------------------------------------------------------
`ifndef BATTERY_BREATHING_LED_DRIVER_UNIT_ASSERT_SVH
`define BATTERY_BREATHING_LED_DRIVER_UNIT_ASSERT_SVH

// same-cycle implication
`define BBLDRV_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BBLDRV_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/bbldrv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbldrv_pkg
// shared types and constants of the battery breathing led driver
// ----------------------------------------------------------------------------
package bbldrv_pkg;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    typedef enum logic [1:0] {
        STAGE_4HZ,
        STAGE_2HZ,
        STAGE_1HZ,
        STAGE_QUARTER_HZ
    } t_stage;

    localparam int unsigned PERIOD_MS = 4000;

    localparam logic [12:0] Q_OFFSET   = 13'd3000;
    localparam logic [10:0] Q_MAX      = 11'd1200;
    localparam logic [10:0] Q_STAGE0   = 11'd180;
    localparam logic [10:0] Q_STAGE1   = 11'd360;
    localparam logic [10:0] Q_STAGE2   = 11'd540;
    localparam logic [10:0] Q_KNEE     = 11'd600;
    localparam logic [6:0]  LEVEL_FULL = 7'd120;
    localparam logic [6:0]  GREEN_BASE = 7'd100;

    // reciprocals: x/5 = x*205>>10, x/30 = x*1093>>15, x/12 = x*2731>>15
    localparam logic [7:0]  RECIP_5   = 8'd205;
    localparam logic [10:0] RECIP_30  = 11'd1093;
    localparam logic [11:0] RECIP_12  = 12'd2731;

    typedef struct packed {
        logic        tick_on;
        logic [6:0]  red;
        logic [6:0]  green;
        logic [10:0] level;
        t_stage      stage;
    } t_item;

endpackage

// File: design/battery_breathing_led_driver_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// battery_breathing_led_driver_unit
// battery charge colour and breathing brightness for a two-colour led
// ----------------------------------------------------------------------------
// one beat in and one beat out per cycle, sustained while m_axis_tready stays
// high; a result passes through the queue register, the registered sine
// lookup and the scaling multiply into the output register. sample beats (tuser 0)
// store charge level, blink stage and colour and return zero drive; tick beats
// (tuser 1) advance the 4000 ms phase and return the stored colour scaled by
// the breathing brightness, or zero when presence is not detected.
module battery_breathing_led_driver_unit #(
    parameter int unsigned SINE_ENTRIES = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // adc_millivolts[11:0], detected[12], zero pad
    input  logic        s_axis_tuser,   // op
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // red_drive[6:0], green_drive[13:7],
                                        // charge_level[24:14], blink_stage[26:25], zero pad
);

    localparam int unsigned IDX_W  = $clog2(SINE_ENTRIES);
    localparam int unsigned ITEM_W = $bits(bbldrv_pkg::t_item);
    localparam int unsigned Q_W    = ITEM_W + IDX_W;

    logic               w_front_valid;
    logic               w_front_ready;
    bbldrv_pkg::t_item  w_front_item;
    logic [IDX_W-1:0]   w_front_idx;
    logic               w_back_valid;
    logic               w_back_ready;
    logic [Q_W-1:0]     w_back_data;
    logic [6:0]         w_red;
    logic [6:0]         w_green;
    logic [10:0]        w_level;
    logic [1:0]         w_stage;

    bbldrv_front #(
        .SINE_ENTRIES (SINE_ENTRIES)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (s_axis_tvalid),
        .o_ready          (s_axis_tready),
        .i_op             (s_axis_tuser),
        .i_adc_millivolts (s_axis_tdata[11:0]),
        .i_detected       (s_axis_tdata[12]),
        .o_valid          (w_front_valid),
        .i_ready          (w_front_ready),
        .o_item           (w_front_item),
        .o_idx            (w_front_idx)
    );

    bbldrv_fifo #(
        .WIDTH (Q_W)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_front_valid),
        .o_ready (w_front_ready),
        .i_data  ({w_front_idx, w_front_item}),
        .o_valid (w_back_valid),
        .i_ready (w_back_ready),
        .o_data  (w_back_data)
    );

    bbldrv_back #(
        .SINE_ENTRIES (SINE_ENTRIES)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (w_back_valid),
        .o_ready        (w_back_ready),
        .i_item         (bbldrv_pkg::t_item'(w_back_data[ITEM_W-1:0])),
        .i_idx          (w_back_data[Q_W-1:ITEM_W]),
        .o_valid        (m_axis_tvalid),
        .i_ready        (m_axis_tready),
        .o_red_drive    (w_red),
        .o_green_drive  (w_green),
        .o_charge_level (w_level),
        .o_blink_stage  (w_stage)
    );

    assign m_axis_tdata = {5'b00000, w_stage, w_level, w_green, w_red};

endmodule

// File: design/bbldrv_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbldrv_front
// accepts sample and tick beats, updates charge, colour and phase state
// ----------------------------------------------------------------------------
module bbldrv_front #(
    parameter int unsigned SINE_ENTRIES = 256,
    localparam int unsigned IDX_W = $clog2(SINE_ENTRIES)
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic                     i_op,
    input  logic [11:0]              i_adc_millivolts,
    input  logic                     i_detected,
    output logic                     o_valid,
    input  logic                     i_ready,
    output bbldrv_pkg::t_item        o_item,
    output logic [IDX_W-1:0]         o_idx
);

    localparam int unsigned IDX_W1 = IDX_W + 1;

    logic [11:0]          r_phase, n_phase;
    logic                 w_phase_wrap;
    bbldrv_pkg::t_stage   r_stage, n_stage;
    logic [6:0]           r_red, n_red;
    logic [6:0]           r_green, n_green;
    logic [10:0]          r_level, n_level;
    logic [IDX_W-1:0]     r_acc_idx [4];
    logic [IDX_W-1:0]     n_acc_idx [4];
    logic [11:0]          r_acc_rem [4];
    logic [11:0]          n_acc_rem [4];

    logic                 w_accept;
    logic                 w_tick;
    logic [12:0]          w_twice;
    logic [12:0]          w_diff;
    logic [10:0]          w_q;
    bbldrv_pkg::t_stage   w_stage;
    logic [10:0]          w_hi_red_x;
    logic [10:0]          w_hi_green_x;
    logic [10:0]          w_mid_x5;
    logic [18:0]          w_red_prod;
    logic [21:0]          w_green_hi_prod;
    logic [22:0]          w_green_mid_prod;
    logic [6:0]           w_red;
    logic [6:0]           w_green;

    assign w_accept = i_valid & o_ready;
    assign w_tick   = (i_op == bbldrv_pkg::OP_TICK);
    assign o_ready  = i_ready;
    assign o_valid  = i_valid;

    // charge level and colour from one sample
    assign w_twice = {i_adc_millivolts, 1'b0};
    assign w_diff  = w_twice - bbldrv_pkg::Q_OFFSET;

    always_comb begin
        if (w_twice < bbldrv_pkg::Q_OFFSET) begin
            w_q = '0;
        end else if (w_diff > {2'b00, bbldrv_pkg::Q_MAX}) begin
            w_q = bbldrv_pkg::Q_MAX;
        end else begin
            w_q = w_diff[10:0];
        end
    end

    always_comb begin
        if (w_q <= bbldrv_pkg::Q_STAGE0) begin
            w_stage = bbldrv_pkg::STAGE_4HZ;
        end else if (w_q <= bbldrv_pkg::Q_STAGE1) begin
            w_stage = bbldrv_pkg::STAGE_2HZ;
        end else if (w_q <= bbldrv_pkg::Q_STAGE2) begin
            w_stage = bbldrv_pkg::STAGE_1HZ;
        end else begin
            w_stage = bbldrv_pkg::STAGE_QUARTER_HZ;
        end
    end

    assign w_hi_red_x       = bbldrv_pkg::Q_MAX - w_q;
    assign w_hi_green_x     = w_q - bbldrv_pkg::Q_KNEE;
    assign w_mid_x5         = 11'((w_q - bbldrv_pkg::Q_STAGE1) * 11'd5);
    assign w_red_prod       = 19'(w_hi_red_x) * 19'(bbldrv_pkg::RECIP_5);
    assign w_green_hi_prod  = 22'(w_hi_green_x) * 22'(bbldrv_pkg::RECIP_30);
    assign w_green_mid_prod = 23'(w_mid_x5) * 23'(bbldrv_pkg::RECIP_12);

    always_comb begin
        if (w_q >= bbldrv_pkg::Q_KNEE) begin
            w_red   = w_red_prod[16:10];
            w_green = bbldrv_pkg::GREEN_BASE + w_green_hi_prod[21:15];
        end else if (w_q >= bbldrv_pkg::Q_STAGE1) begin
            w_red   = bbldrv_pkg::LEVEL_FULL;
            w_green = w_green_mid_prod[21:15];
        end else begin
            w_red   = bbldrv_pkg::LEVEL_FULL;
            w_green = '0;
        end
    end

    // one phase accumulator per blink stage: index and remainder of r*n/4000
    assign w_phase_wrap = (r_phase == 12'(bbldrv_pkg::PERIOD_MS - 1));

    for (genvar s = 0; s < 4; s++) begin : g_acc
        localparam int unsigned MULT   = (s == 3) ? 1 : (16 >> s);
        localparam int unsigned STEP_Q = MULT * SINE_ENTRIES / bbldrv_pkg::PERIOD_MS;
        localparam int unsigned STEP_R = MULT * SINE_ENTRIES % bbldrv_pkg::PERIOD_MS;

        logic [12:0]       w_rem_sum;
        logic              w_carry;
        logic [IDX_W1-1:0] w_idx_sum;

        assign w_rem_sum = {1'b0, r_acc_rem[s]} + 13'(STEP_R);
        assign w_carry   = (w_rem_sum >= 13'(bbldrv_pkg::PERIOD_MS));
        assign w_idx_sum = {1'b0, r_acc_idx[s]} + IDX_W1'(STEP_Q) + IDX_W1'(w_carry);

        assign n_acc_rem[s] = w_phase_wrap ? '0 :
                              w_carry ? 12'(w_rem_sum - 13'(bbldrv_pkg::PERIOD_MS)) :
                              w_rem_sum[11:0];
        assign n_acc_idx[s] = w_phase_wrap ? '0 :
                              (w_idx_sum >= IDX_W1'(SINE_ENTRIES)) ?
                              IDX_W'(w_idx_sum - IDX_W1'(SINE_ENTRIES)) :
                              w_idx_sum[IDX_W-1:0];
    end

    assign n_phase = w_phase_wrap ? '0 : r_phase + 12'd1;

    always_comb begin
        n_stage = r_stage;
        n_red   = r_red;
        n_green = r_green;
        n_level = r_level;
        if (!w_tick) begin
            n_stage = w_stage;
            n_red   = w_red;
            n_green = w_green;
            n_level = w_q;
        end
    end

    assign o_item.tick_on = w_tick & i_detected;
    assign o_item.red     = n_red;
    assign o_item.green   = n_green;
    assign o_item.level   = n_level;
    assign o_item.stage   = n_stage;
    assign o_idx          = n_acc_idx[n_stage];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
            r_stage <= bbldrv_pkg::STAGE_QUARTER_HZ;
            r_red   <= '0;
            r_green <= '0;
            r_level <= '0;
            for (int s = 0; s < 4; s++) begin
                r_acc_idx[s] <= '0;
                r_acc_rem[s] <= '0;
            end
        end else if (w_accept) begin
            r_stage <= n_stage;
            r_red   <= n_red;
            r_green <= n_green;
            r_level <= n_level;
            if (w_tick) begin
                r_phase <= n_phase;
                for (int s = 0; s < 4; s++) begin
                    r_acc_idx[s] <= n_acc_idx[s];
                    r_acc_rem[s] <= n_acc_rem[s];
                end
            end
        end
    end

`include "battery_breathing_led_driver_unit_assert.svh"

    `BBLDRV_ASSERT_NOW(a_phase_zero_acc, i_clk, i_rst_n, r_phase == 12'd0, (r_acc_idx[0] == '0) && (r_acc_rem[0] == 12'd0), "accumulator not aligned with phase start")

endmodule

// File: design/bbldrv_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbldrv_fifo
// two-entry queue between the front and the back
// ----------------------------------------------------------------------------
module bbldrv_fifo #(
    parameter int unsigned WIDTH = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [WIDTH-1:0] o_data
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wr_ptr;
    logic             r_rd_ptr;
    logic [1:0]       r_count;
    logic             w_push;
    logic             w_pop;

    assign o_ready = (r_count != 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_mem[r_rd_ptr];
    assign w_push  = i_valid & o_ready;
    assign w_pop   = o_valid & i_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= r_count + 2'(w_push) - 2'(w_pop);
        end
    end

`include "battery_breathing_led_driver_unit_assert.svh"

    `BBLDRV_ASSERT_NOW(a_count_track, i_clk, i_rst_n, $past(i_rst_n), r_count == 2'($past(r_count) + 2'($past(w_push)) - 2'($past(w_pop))), "queue fill count out of step")

endmodule

// File: design/bbldrv_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbldrv_back
// sine brightness lookup and colour scaling into the output register
// ----------------------------------------------------------------------------
module bbldrv_back #(
    parameter int unsigned SINE_ENTRIES = 256,
    localparam int unsigned IDX_W = $clog2(SINE_ENTRIES)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  bbldrv_pkg::t_item  i_item,
    input  logic [IDX_W-1:0]   i_idx,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [6:0]         o_red_drive,
    output logic [6:0]         o_green_drive,
    output logic [10:0]        o_charge_level,
    output logic [1:0]         o_blink_stage
);

    localparam logic [63:0] COEF_A = 64'd102944;
    localparam logic [63:0] COEF_B = 64'd42047;
    localparam logic [63:0] COEF_C = 64'd4639;

    function automatic logic [8:0] wave_entry(input int unsigned i);
        logic [63:0] pos;
        logic [63:0] quad;
        logic [63:0] u;
        logic [63:0] u2;
        logic [63:0] u3;
        logic [63:0] u5;
        logic [63:0] s;
        logic [63:0] e;
        pos  = 64'(4 * i);
        quad = pos / SINE_ENTRIES;
        u    = ((pos % SINE_ENTRIES) << 16) / SINE_ENTRIES;
        if (quad[0]) begin
            u = 64'd65536 - u;
        end
        u2 = (u * u) >> 16;
        u3 = (u2 * u) >> 16;
        u5 = (u3 * u2) >> 16;
        s  = (COEF_A * u + COEF_C * u5 - COEF_B * u3) >> 16;
        if (s > 64'd65536) begin
            s = 64'd65536;
        end
        if (quad >= 64'd2) begin
            e = (64'd65536 - s + 64'd256) >> 9;
        end else begin
            e = (64'd65536 + s + 64'd256) >> 9;
        end
        return e[8:0];
    endfunction

    logic [8:0] w_wave [SINE_ENTRIES];

    for (genvar g = 0; g < SINE_ENTRIES; g++) begin : g_wave
        assign w_wave[g] = wave_entry(g);
    end

    logic               r_s1_valid;
    logic [8:0]         r_s1_bright;
    bbldrv_pkg::t_item  r_s1_item;
    logic               r_out_valid;
    logic [6:0]         r_out_red;
    logic [6:0]         r_out_green;
    logic [10:0]        r_out_level;
    bbldrv_pkg::t_stage r_out_stage;
    logic               w_out_adv;
    logic               w_s1_adv;
    logic [15:0]        w_red_prod;
    logic [15:0]        w_green_prod;

    assign w_out_adv = !r_out_valid || i_ready;
    assign w_s1_adv  = !r_s1_valid || w_out_adv;
    assign o_ready   = w_s1_adv;

    assign w_red_prod   = 16'(r_s1_item.red) * 16'(r_s1_bright);
    assign w_green_prod = 16'(r_s1_item.green) * 16'(r_s1_bright);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_s1_adv) begin
                r_s1_valid <= i_valid;
            end
            if (w_out_adv) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_adv && i_valid) begin
            r_s1_item   <= i_item;
            r_s1_bright <= i_item.tick_on ? w_wave[i_idx] : 9'd0;
        end
        if (w_out_adv && r_s1_valid) begin
            r_out_red   <= w_red_prod[14:8];
            r_out_green <= w_green_prod[14:8];
            r_out_level <= r_s1_item.level;
            r_out_stage <= r_s1_item.stage;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_red_drive    = r_out_red;
    assign o_green_drive  = r_out_green;
    assign o_charge_level = r_out_level;
    assign o_blink_stage  = r_out_stage;

`include "battery_breathing_led_driver_unit_assert.svh"

    `BBLDRV_ASSERT_NOW(a_bright_range, i_clk, i_rst_n, r_s1_valid, r_s1_bright <= 9'd256, "brightness above full scale")
    `BBLDRV_ASSERT_NEXT(a_s1_hold, i_clk, i_rst_n, r_s1_valid && !w_out_adv, r_s1_valid, "lookup stage dropped while output stalled")

endmodule

// File: sim/tb_battery_breathing_led_driver_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_battery_breathing_led_driver_unit
// self-checking bench for the battery breathing led driver
// ----------------------------------------------------------------------------
// battery samples and millisecond ticks go in on the slave stream. Each
// accepted beat is run through a local model of the charge-level mapping and
// the sine-table breathing brightness, and the expected drive, level and
// stage are queued. Every output beat is checked field by field against the
// oldest entry. Directed tests cover the reset state and the charge-level
// boundaries. Further tests cover a back-to-back burst with no idle cycles,
// a long output stall that fills the block, and a random mix of beats with
// idle cycles on both sides.
module tb_battery_breathing_led_driver_unit;

    localparam int unsigned BREATH_STEPS = 256;
    localparam int unsigned STALL_CYCLES = 200;
    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned IDLE_PCT     = 37;
    localparam int unsigned BURST_BEATS  = 240;
    localparam int unsigned RANDOM_BEATS = 1100;

    typedef struct packed {
        logic [6:0]           red;
        logic [6:0]           green;
        logic [10:0]          level;
        bbldrv_pkg::t_stage   stage;
    } t_led_drive;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;   // adc_millivolts[11:0], detected[12], zero pad
    logic        s_axis_tuser = bbldrv_pkg::OP_SAMPLE;  // op
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;   // red[6:0], green[13:7], level[24:14], stage[26:25]

    logic        steady = 1'b0;
    logic        stall_start = 1'b0;
    int unsigned stall_left = 0;
    int unsigned cycle_count = 0;
    int unsigned mismatch_count = 0;

    logic [8:0]           breath_lut [BREATH_STEPS];
    int unsigned          phase_ms;
    bbldrv_pkg::t_stage   blink_stage;
    logic [6:0]           red_level;
    logic [6:0]           green_level;
    logic [10:0]          charge_level;
    t_led_drive           pending_drives[$];

    battery_breathing_led_driver_unit #(
        .SINE_ENTRIES(BREATH_STEPS)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Mismatches found");
            $finish;
        end
    end

    // long output hold-off, counted here
    always @(posedge i_clk) begin
        if (stall_start) begin
            stall_left <= STALL_CYCLES;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
        end
    end

    always @(posedge i_clk) begin
        if (stall_start || stall_left > 1) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch at cycle %0d: %s", cycle_count, msg);
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin
        t_led_drive want;
        t_led_drive got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = {m_axis_tdata[6:0], m_axis_tdata[13:7], m_axis_tdata[24:14],
                   bbldrv_pkg::t_stage'(m_axis_tdata[26:25])};
            if (pending_drives.size() == 0) begin
                report_mismatch($sformatf("unexpected beat %h", m_axis_tdata));
            end else begin
                want = pending_drives.pop_front();
                if (got.red != want.red)
                    report_mismatch($sformatf("red %0d, want %0d", got.red, want.red));
                if (got.green != want.green)
                    report_mismatch($sformatf("green %0d, want %0d", got.green, want.green));
                if (got.level != want.level)
                    report_mismatch($sformatf("level %0d, want %0d", got.level, want.level));
                if (got.stage != want.stage)
                    report_mismatch($sformatf("stage %0d, want %0d", got.stage, want.stage));
            end
        end
    end

    function automatic longint unsigned quarter_wave(input longint unsigned u);
        longint unsigned u2, u3, u5, s;
        u2 = (u * u) >> 16;
        u3 = (u2 * u) >> 16;
        u5 = (u3 * u2) >> 16;
        s = (64'd102944 * u + 64'd4639 * u5 - 64'd42047 * u3) >> 16;
        return (s > 65536) ? 64'd65536 : s;
    endfunction

    function automatic void build_breath_lut();
        longint unsigned pos, quad, u, s;
        for (int i = 0; i < BREATH_STEPS; i++) begin
            pos = 4 * i;
            quad = pos / BREATH_STEPS;
            u = ((pos % BREATH_STEPS) << 16) / BREATH_STEPS;
            if (quad[0]) u = 65536 - u;
            s = quarter_wave(u);
            if (quad >= 2) breath_lut[i] = 9'((65536 - s + 256) >> 9);
            else breath_lut[i] = 9'((65536 + s + 256) >> 9);
        end
    endfunction

    function automatic t_led_drive predict_led(input logic op, input logic [11:0] mv,
                                               input logic det);
        t_led_drive  res;
        int          q;
        int unsigned mult, idx, b;
        res.red = '0;
        res.green = '0;
        if (op == bbldrv_pkg::OP_SAMPLE) begin
            q = 2 * int'(mv) - 3000;
            if (q < 0) q = 0;
            if (q > 1200) q = 1200;
            charge_level = 11'(q);
            if (q <= 180) blink_stage = bbldrv_pkg::STAGE_4HZ;
            else if (q <= 360) blink_stage = bbldrv_pkg::STAGE_2HZ;
            else if (q <= 540) blink_stage = bbldrv_pkg::STAGE_1HZ;
            else blink_stage = bbldrv_pkg::STAGE_QUARTER_HZ;
            if (q >= 600) begin
                red_level = 7'((1200 - q) / 5);
                green_level = 7'(100 + (q - 600) / 30);
            end else if (q >= 360) begin
                red_level = 7'd120;
                green_level = 7'(5 * (q - 360) / 12);
            end else begin
                red_level = 7'd120;
                green_level = 7'd0;
            end
        end else begin
            phase_ms = (phase_ms + 1 >= bbldrv_pkg::PERIOD_MS) ? 0 : phase_ms + 1;
            if (det) begin
                case (blink_stage)
                    bbldrv_pkg::STAGE_4HZ: mult = 16;
                    bbldrv_pkg::STAGE_2HZ: mult = 8;
                    bbldrv_pkg::STAGE_1HZ: mult = 4;
                    default:               mult = 1;
                endcase
                idx = (phase_ms * mult * BREATH_STEPS / bbldrv_pkg::PERIOD_MS) % BREATH_STEPS;
                b = breath_lut[idx];
                res.red = 7'((red_level * b) >> 8);
                res.green = 7'((green_level * b) >> 8);
            end
        end
        res.level = charge_level;
        res.stage = blink_stage;
        return res;
    endfunction

    task automatic send_beat(input logic op, input logic [11:0] mv, input logic det);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= op;
        s_axis_tdata <= {3'b000, det, mv};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        pending_drives.push_back(predict_led(op, mv, det));
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_drives.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [11:0] pick_millivolts();
        if ($urandom_range(0, 3) == 0) return 12'($urandom_range(0, 4095));
        return 12'($urandom_range(1450, 2150));
    endfunction

    task automatic test_reset_state();
        send_beat(bbldrv_pkg::OP_TICK, 12'd0, 1'b1);
        send_beat(bbldrv_pkg::OP_TICK, 12'hfff, 1'b0);
        send_beat(bbldrv_pkg::OP_TICK, 12'd0, 1'b1);
    endtask

    task automatic test_charge_levels();
        logic [11:0] mv_points [9] = '{12'd0, 12'd1590, 12'd1591, 12'd1680, 12'd1770,
                                       12'd1799, 12'd1800, 12'd2100, 12'd4095};
        foreach (mv_points[i]) begin
            send_beat(bbldrv_pkg::OP_SAMPLE, mv_points[i], 1'b0);
            send_beat(bbldrv_pkg::OP_TICK, 12'd0, 1'b1);
        end
    endtask

    task automatic test_steady_burst();
        steady = 1'b1;
        send_beat(bbldrv_pkg::OP_SAMPLE, pick_millivolts(), 1'b1);
        repeat (BURST_BEATS) begin
            send_beat(bbldrv_pkg::OP_TICK, 12'($urandom), ($urandom_range(0, 9) != 0));
        end
        steady = 1'b0;
    endtask

    task automatic test_output_stall();
        wait_drained();
        stall_start <= 1'b1;
        @(posedge i_clk);
        stall_start <= 1'b0;
        send_beat(bbldrv_pkg::OP_SAMPLE, pick_millivolts(), 1'b0);
        repeat (40) send_beat(bbldrv_pkg::OP_TICK, 12'($urandom), 1'b1);
        wait_drained();
    endtask

    task automatic test_random_mix();
        repeat (RANDOM_BEATS) begin
            if ($urandom_range(0, 99) < 20) begin
                send_beat(bbldrv_pkg::OP_SAMPLE, pick_millivolts(), 1'($urandom));
            end else begin
                send_beat(bbldrv_pkg::OP_TICK, 12'($urandom), ($urandom_range(0, 4) != 0));
            end
        end
    endtask

    initial begin
        build_breath_lut();
        phase_ms = 0;
        blink_stage = bbldrv_pkg::STAGE_QUARTER_HZ;
        red_level = '0;
        green_level = '0;
        charge_level = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_state();
        test_charge_levels();
        test_steady_burst();
        test_output_stall();
        test_random_mix();

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
